// ----- src/ccg_pkg.sv -----
// ccg_pkg: shared types and codes for the coverage count grid.
// No dependencies; imported by every module of the block.
package ccg_pkg;

    // grid side; the 7-bit cell ports and 8-bit dimension registers fix it
    localparam int MAX_DIM = 128;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_UPDATE = 3'd2;
    localparam logic [2:0] OP_QUERY  = 3'd3;
    localparam logic [2:0] OP_SUB    = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam logic [1:0] EV_COVERED   = 2'd0;
    localparam logic [1:0] EV_UNCOVERED = 2'd1;
    localparam logic [1:0] EV_DONE      = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    // one source region
    typedef struct packed {
        logic [6:0] x;
        logic [6:0] y;
        logic [1:0] reach;
        logic [2:0] fp;
        logic       active;
    } region_t;

endpackage

// ----- src/coverage_count_grid_unit.sv -----
// coverage_count_grid_unit: top level of the coverage count grid.
// Depends on ccg_pkg and ccg_region_test.
//
// Keeps a saturating coverage count per grid cell in one synchronous memory
// with one read and one write port (MAX_DIM*MAX_DIM words, registered read)
// and handles one item at a time. Add, remove and update scan their box
// twice (increment beat first, decrement beat second), column outer, row
// inner: a cell that needs no change passes S_SCAN alone, a cell that is
// read, modified and written back S_SCAN and S_MOD, and each covered or
// uncovered beat waits in S_EMIT until the output register is free. An
// update with distant old and new positions scans their whole bounding
// box. Query and subtract read their cell through S_CELLRD and S_CELL.
// Clear, a write to either dimension register, and reset run a clearing
// pass over all MAX_DIM^2 words (16384 at the default) during which no
// item is accepted; config writes are taken only while the unit is idle
// and no item is offered. Results leave through an output register, so a
// new item is accepted while the final done beat still waits.
module coverage_count_grid_unit
    import ccg_pkg::*;
#(
    parameter int MAX_REACH  = 2,
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [6:0]  pos_x,
    input  logic [6:0]  pos_y,
    input  logic [1:0]  reach,
    input  logic [2:0]  footprint,
    input  logic        square_shape,
    input  logic [6:0]  old_x,
    input  logic [6:0]  old_y,
    input  logic [1:0]  old_reach,
    input  logic [2:0]  old_footprint,
    input  logic [15:0] amount,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  cell_x,
    output logic [6:0]  cell_y,
    output logic [1:0]  event_kind,
    output logic        covered,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int AW        = $clog2(DEPTH);
    localparam int DIM_RESET = (MAX_DIM < 128) ? MAX_DIM : 128;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SWEEP  = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_MOD    = 8'b0000_1000,
        S_EMIT   = 8'b0001_0000,
        S_CELLRD = 8'b0010_0000,
        S_CELL   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [7:0] x, input logic [7:0] y);
        cell_addr = AW'(int'(y) * MAX_DIM + int'(x));
    endfunction

    function automatic logic [1:0] cap_reach(input logic [1:0] r);
        cap_reach = (int'(r) > MAX_REACH) ? 2'(MAX_REACH) : r;
    endfunction

    function automatic logic [7:0] clamp_dim(input logic [7:0] v);
        if (v == 8'd0)
            clamp_dim = 8'd1;
        else if (int'(v) > MAX_DIM)
            clamp_dim = 8'(MAX_DIM);
        else
            clamp_dim = v;
    endfunction

    // control state
    state_t          state_reg, state_next;
    logic [AW-1:0]   sw_reg, sw_next;
    logic            sw_done_reg, sw_done_next;
    logic [7:0]      map_w_reg, map_w_next, map_h_reg, map_h_next;
    logic            out_valid_reg, out_valid_next;
    logic            inc_pass_reg, inc_pass_next;

    // item payload
    logic [2:0]      op_reg, op_next;
    region_t         nrg_reg, nrg_next, org_reg, org_next;
    logic            sq_reg, sq_next;
    logic [7:0]      lox_reg, lox_next, hix_reg, hix_next;
    logic [7:0]      loy_reg, loy_next, hiy_reg, hiy_next;
    logic [7:0]      cx_reg, cx_next, cy_reg, cy_next;
    logic [15:0]     amt_reg, amt_next;
    logic            cov_reg, cov_next;
    logic [1:0]      ev_kind_reg, ev_kind_next;

    // output register
    logic [6:0]      ox_reg, ox_next, oy_reg, oy_next;
    logic [1:0]      okind_reg, okind_next;
    logic            ocov_reg, ocov_next, olast_reg, olast_next;

    // memory
    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_q, wdata;
    logic [AW-1:0]         waddr, raddr;
    logic                  mem_we;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        rd_q <= mem[raddr];
    end

    // region membership of the current cell
    logic n_hit, o_hit, act;

    ccg_region_test u_new_test (.rgn(nrg_reg), .cx(cx_reg), .cy(cy_reg),
                                .sq(sq_reg), .hit(n_hit));
    ccg_region_test u_old_test (.rgn(org_reg), .cx(cx_reg), .cy(cy_reg),
                                .sq(sq_reg), .hit(o_hit));

    assign act = inc_pass_reg ? (n_hit && !o_hit) : (!n_hit && o_hit);

    // scan box advance
    logic       row_end, col_end, scan_fin;
    logic [7:0] adv_cx, adv_cy;
    logic       adv_inc;

    always_comb
    begin
        row_end  = (cy_reg == hiy_reg);
        col_end  = (cx_reg == hix_reg);
        scan_fin = row_end && col_end && !inc_pass_reg;
        adv_cx   = cx_reg;
        adv_cy   = cy_reg + 8'd1;
        adv_inc  = inc_pass_reg;
        if (row_end)
        begin
            adv_cy = loy_reg;
            if (!col_end)
            begin
                adv_cx = cx_reg + 8'd1;
            end
            else
            begin
                adv_cx  = lox_reg;
                adv_inc = 1'b0;
            end
        end
    end

    // scan box of a new item
    region_t          reg_a, reg_b;
    logic [6:0]       bx_lo, bx_hi, by_lo, by_hi;
    logic [1:0]       rr;
    logic signed [9:0] lx10, ly10;
    logic [9:0]       hx10, hy10;
    logic [7:0]       box_lox, box_hix, box_loy, box_hiy;
    logic [7:0]       wm1, hm1;
    logic             box_empty;

    always_comb
    begin
        reg_a = '{x: pos_x, y: pos_y, reach: cap_reach(reach), fp: footprint,
                  active: 1'b1};
        reg_b = '{x: old_x, y: old_y, reach: cap_reach(old_reach), fp: old_footprint,
                  active: 1'b1};
        if (opcode == OP_UPDATE)
        begin
            bx_lo = (pos_x < old_x) ? pos_x : old_x;
            bx_hi = (pos_x > old_x) ? pos_x : old_x;
            by_lo = (pos_y < old_y) ? pos_y : old_y;
            by_hi = (pos_y > old_y) ? pos_y : old_y;
            rr    = (reg_a.reach > reg_b.reach) ? reg_a.reach : reg_b.reach;
        end
        else
        begin
            bx_lo = pos_x;
            bx_hi = pos_x;
            by_lo = pos_y;
            by_hi = pos_y;
            rr    = reg_a.reach;
        end
        wm1  = map_w_reg - 8'd1;
        hm1  = map_h_reg - 8'd1;
        lx10 = $signed({3'b000, bx_lo}) - $signed({8'd0, rr});
        ly10 = $signed({3'b000, by_lo}) - $signed({8'd0, rr});
        hx10 = {3'b000, bx_hi} + {8'd0, rr};
        hy10 = {3'b000, by_hi} + {8'd0, rr};
        box_lox = lx10[9] ? 8'd0 : lx10[7:0];
        box_loy = ly10[9] ? 8'd0 : ly10[7:0];
        box_hix = (hx10 > {2'b00, wm1}) ? wm1 : hx10[7:0];
        box_hiy = (hy10 > {2'b00, hm1}) ? hm1 : hy10[7:0];
        box_empty = (box_lox > box_hix) || (box_loy > box_hiy);
    end

    // config only between items, and never in the same cycle as an item beat
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !in_valid;

    logic                  out_free;
    logic [COUNT_BITS-1:0] sub_val;

    assign out_free = !out_valid_reg || out_ready;
    assign raddr    = cell_addr(cx_reg, cy_reg);

    always_comb
    begin
        state_next     = state_reg;
        sw_next        = sw_reg;
        sw_done_next   = sw_done_reg;
        map_w_next     = map_w_reg;
        map_h_next     = map_h_reg;
        inc_pass_next  = inc_pass_reg;
        op_next        = op_reg;
        nrg_next       = nrg_reg;
        org_next       = org_reg;
        sq_next        = sq_reg;
        lox_next       = lox_reg;
        hix_next       = hix_reg;
        loy_next       = loy_reg;
        hiy_next       = hiy_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        amt_next       = amt_reg;
        cov_next       = cov_reg;
        ev_kind_next   = ev_kind_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        okind_next     = okind_reg;
        ocov_next      = ocov_reg;
        olast_next     = olast_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_we         = 1'b0;
        waddr          = raddr;
        wdata          = '0;
        sub_val        = (16'(rd_q) > amt_reg) ? COUNT_BITS'(16'(rd_q) - amt_reg) : '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = opcode;
                    sq_next       = square_shape;
                    amt_next      = amount;
                    cov_next      = 1'b0;
                    cx_next       = {1'b0, pos_x};
                    cy_next       = {1'b0, pos_y};
                    lox_next      = box_lox;
                    hix_next      = box_hix;
                    loy_next      = box_loy;
                    hiy_next      = box_hiy;
                    inc_pass_next = 1'b1;
                    nrg_next      = reg_a;
                    org_next      = reg_b;
                    state_next    = S_DONE;
                    unique case (opcode) inside
                        OP_ADD, OP_REMOVE, OP_UPDATE:
                        begin
                            if (opcode == OP_ADD)
                                org_next.active = 1'b0;
                            if (opcode == OP_REMOVE)
                            begin
                                org_next        = reg_a;
                                nrg_next.active = 1'b0;
                            end
                            cx_next = box_lox;
                            cy_next = box_loy;
                            if (!box_empty)
                                state_next = S_SCAN;
                        end
                        OP_QUERY, OP_SUB:
                        begin
                            if ({1'b0, pos_x} < map_w_reg && {1'b0, pos_y} < map_h_reg)
                                state_next = S_CELLRD;
                        end
                        OP_CLEAR:
                        begin
                            sw_next      = '0;
                            sw_done_next = 1'b1;
                            state_next   = S_SWEEP;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                mem_we  = 1'b1;
                waddr   = sw_reg;
                wdata   = '0;
                sw_next = sw_reg + AW'(1);
                if (sw_reg == AW'(DEPTH - 1))
                    state_next = sw_done_reg ? S_DONE : S_IDLE;
            end
            S_SCAN:
            begin
                if (act)
                begin
                    state_next = S_MOD;
                end
                else
                begin
                    cx_next       = adv_cx;
                    cy_next       = adv_cy;
                    inc_pass_next = adv_inc;
                    if (scan_fin)
                        state_next = S_DONE;
                end
            end
            S_MOD:
            begin
                cx_next       = adv_cx;
                cy_next       = adv_cy;
                inc_pass_next = adv_inc;
                state_next    = scan_fin ? S_DONE : S_SCAN;
                if (inc_pass_reg)
                begin
                    if (rd_q != COUNT_MAX)
                    begin
                        mem_we = 1'b1;
                        wdata  = rd_q + COUNT_ONE;
                        if (rd_q == '0)
                        begin
                            ev_kind_next  = EV_COVERED;
                            cx_next       = cx_reg;
                            cy_next       = cy_reg;
                            inc_pass_next = inc_pass_reg;
                            state_next    = S_EMIT;
                        end
                    end
                end
                else
                begin
                    if (rd_q != '0)
                    begin
                        mem_we = 1'b1;
                        wdata  = rd_q - COUNT_ONE;
                        if (rd_q == COUNT_ONE)
                        begin
                            ev_kind_next  = EV_UNCOVERED;
                            cx_next       = cx_reg;
                            cy_next       = cy_reg;
                            inc_pass_next = inc_pass_reg;
                            state_next    = S_EMIT;
                        end
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ox_next        = cx_reg[6:0];
                    oy_next        = cy_reg[6:0];
                    okind_next     = ev_kind_reg;
                    ocov_next      = 1'b0;
                    olast_next     = 1'b0;
                    if (op_reg == OP_SUB)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cx_next       = adv_cx;
                        cy_next       = adv_cy;
                        inc_pass_next = adv_inc;
                        state_next    = scan_fin ? S_DONE : S_SCAN;
                    end
                end
            end
            S_CELLRD:
            begin
                state_next = S_CELL;
            end
            S_CELL:
            begin
                state_next = S_DONE;
                if (op_reg == OP_QUERY)
                begin
                    cov_next = (rd_q != '0);
                end
                else
                begin
                    mem_we = 1'b1;
                    wdata  = sub_val;
                    if (rd_q != '0 && sub_val == '0)
                    begin
                        ev_kind_next = EV_UNCOVERED;
                        state_next   = S_EMIT;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ox_next        = 7'd0;
                    oy_next        = 7'd0;
                    okind_next     = EV_DONE;
                    ocov_next      = cov_reg;
                    olast_next     = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a dimension write clears the store
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WIDTH:
                begin
                    map_w_next   = clamp_dim(cfg_data);
                    sw_next      = '0;
                    sw_done_next = 1'b0;
                    state_next   = S_SWEEP;
                end
                REG_HEIGHT:
                begin
                    map_h_next   = clamp_dim(cfg_data);
                    sw_next      = '0;
                    sw_done_next = 1'b0;
                    state_next   = S_SWEEP;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            sw_reg        <= '0;
            sw_done_reg   <= 1'b0;
            map_w_reg     <= 8'(DIM_RESET);
            map_h_reg     <= 8'(DIM_RESET);
            out_valid_reg <= 1'b0;
            inc_pass_reg  <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            sw_reg        <= sw_next;
            sw_done_reg   <= sw_done_next;
            map_w_reg     <= map_w_next;
            map_h_reg     <= map_h_next;
            out_valid_reg <= out_valid_next;
            inc_pass_reg  <= inc_pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        nrg_reg     <= nrg_next;
        org_reg     <= org_next;
        sq_reg      <= sq_next;
        lox_reg     <= lox_next;
        hix_reg     <= hix_next;
        loy_reg     <= loy_next;
        hiy_reg     <= hiy_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        amt_reg     <= amt_next;
        cov_reg     <= cov_next;
        ev_kind_reg <= ev_kind_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        okind_reg   <= okind_next;
        ocov_reg    <= ocov_next;
        olast_reg   <= olast_next;
    end

    assign out_valid  = out_valid_reg;
    assign cell_x     = ox_reg;
    assign cell_y     = oy_reg;
    assign event_kind = okind_reg;
    assign covered    = ocov_reg;
    assign last       = olast_reg;

endmodule

// ----- src/ccg_region_test.sv -----
// ccg_region_test: decides whether a cell lies inside one source region.
// Depends on ccg_pkg (region_t).
module ccg_region_test
    import ccg_pkg::*;
(
    input  region_t    rgn,
    input  logic [7:0] cx,
    input  logic [7:0] cy,
    input  logic       sq,
    output logic       hit
);

    logic signed [10:0] dx, dy;
    logic        [10:0] ax, ay, m;
    logic signed [21:0] dx2, dy2;
    logic        [22:0] dsum;
    logic        [3:0]  r2;

    always_comb
    begin
        // doubled offset from the footprint centre
        dx = $signed({2'b00, cx, 1'b0}) - $signed({3'b000, rgn.x, 1'b0})
             - $signed({8'd0, rgn.fp}) + 11'sd1;
        dy = $signed({2'b00, cy, 1'b0}) - $signed({3'b000, rgn.y, 1'b0})
             - $signed({8'd0, rgn.fp}) + 11'sd1;
        ax   = dx[10] ? 11'(-dx) : 11'(dx);
        ay   = dy[10] ? 11'(-dy) : 11'(dy);
        m    = (ax > ay) ? ax : ay;
        dx2  = dx * dx;
        dy2  = dy * dy;
        dsum = {1'b0, dx2} + {1'b0, dy2};
        r2   = {2'b00, rgn.reach} * {2'b00, rgn.reach};
        if (sq)
        begin
            hit = rgn.active && (m <= {8'd0, rgn.reach, 1'b0});
        end
        else
        begin
            hit = rgn.active && (dsum <= {17'd0, r2, 2'b00});
        end
    end

endmodule

// ----- src/ccg_checker.sv -----
// ccg_checker: port-level checks on the result channel of the grid unit.
// Depends on ccg_pkg; bound to coverage_count_grid_unit below.
module ccg_checker
    import ccg_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] cell_x,
    input logic [6:0] cell_y,
    input logic [1:0] event_kind,
    input logic       covered,
    input logic       last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind)
            && $stable(cell_x) && $stable(cell_y) && $stable(last))
        else $error("result beat changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_kind != 2'd3)
        else $error("unknown event kind");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (event_kind == EV_DONE)))
        else $error("last not on done beat alone");

    a_done_cell: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> cell_x == 7'd0 && cell_y == 7'd0)
        else $error("done beat carries a cell");

    a_cov: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_DONE |-> !covered)
        else $error("covered set on an event beat");

endmodule

bind coverage_count_grid_unit ccg_checker u_ccg_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .cell_x(cell_x), .cell_y(cell_y), .event_kind(event_kind),
    .covered(covered), .last(last)
);
